// ----- hdl/pfa_pkg.sv -----
// Shared constants, codes and types of the page frame allocator.
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int MAX_PAGES       = 4096;
  localparam int PAGE_BYTES      = 4096;
  localparam int BIG_ALIGN_BYTES = 2097152;
  localparam int MIB_BYTES       = 1048576;
  localparam int ADDR_W          = 48;

  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int ALIGN_BYTES = (BIG_ALIGN_BYTES > MIB_BYTES) ? BIG_ALIGN_BYTES : MIB_BYTES;
  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
  localparam int ALIGN_PG_W  = ALIGN_SHIFT - PAGE_SHIFT;

  localparam int IDX_W    = $clog2(MAX_PAGES);
  localparam int CNT_W    = IDX_W + 1;
  localparam int ROW_BITS = 64;
  localparam int BIT_W    = $clog2(ROW_BITS);
  localparam int ROWS     = MAX_PAGES / ROW_BITS;
  localparam int ROW_W    = $clog2(ROWS);

  localparam int CFG_W     = ADDR_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGES = 1'd1;

  localparam logic [1:0] CMD_PAGE = 2'd0;
  localparam logic [1:0] CMD_BIG  = 2'd1;
  localparam logic [1:0] CMD_FREE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef struct packed {
    logic                en;
    logic [ROW_W-1:0]    row;
    logic [ROW_BITS-1:0] data;
  } row_write_t;

endpackage

// ----- hdl/page_frame_allocator.sv -----
// Top level of the first-fit page frame allocator.
//
//   Channel  Direction  Handshake            Word
//   cfg      in         cfg_write            cfg_index, cfg_data
//   in       in         in_valid / in_ready  cmd, free_address
//   out      out        out_valid/out_ready  page_address, status
//
// An allocation scans the bitmap one 64-flag row per cycle until it finds a
// free page or reaches the last row of the pool.
// A free reads and rewrites the row of its page; an address outside the pool skips the write.
// An unused command or a request to an empty pool goes straight to the result.
// One word is worked on at a time; in_ready is high only while idle.
// Reset clears all row valid bits at once, so no clearing pass is needed.
// A finished result waits in the block until the output register is free.
`timescale 1ns / 1ps

module page_frame_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic [pfa_pkg::ADDR_W-1:0]      free_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pfa_pkg::ADDR_W-1:0]      page_address,
  output logic [1:0]                      status
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_FCHK = 5'b00100,
    S_FWR  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                         state;
  logic [pfa_pkg::ADDR_W-1:0]     pool_base;
  logic [pfa_pkg::CNT_W-1:0]      pool_pages;
  logic                           big;
  logic [pfa_pkg::ADDR_W-1:0]     faddr;
  logic [pfa_pkg::ROW_W-1:0]      scan_row;
  logic                           scan_done;
  logic [pfa_pkg::ROW_W-1:0]      chk_row;
  logic                           chk_valid;
  logic [pfa_pkg::IDX_W-1:0]      hit_idx;
  logic                           fin_hit;
  pfa_pkg::status_t               fin_status;

  logic [pfa_pkg::CNT_W-1:0]      n_pages;
  logic [pfa_pkg::CNT_W-1:0]      n_minus1;
  logic [pfa_pkg::ROW_W-1:0]      last_row;
  logic [pfa_pkg::CNT_W-pfa_pkg::BIT_W-1:0] full_rows;
  logic [pfa_pkg::BIT_W-1:0]      rem_bits;
  logic [pfa_pkg::ROW_BITS-1:0]   vmask;
  logic [pfa_pkg::ROW_BITS-1:0]   cand;
  logic [pfa_pkg::ROW_BITS-1:0]   avail;
  logic [pfa_pkg::ALIGN_PG_W-1:0] align_target;
  logic                           base_page_ok;
  logic [pfa_pkg::IDX_W-1:0]      bit_idx;
  logic [pfa_pkg::BIT_W-1:0]      first_bit;
  logic                           hit;
  logic [pfa_pkg::ADDR_W-1:0]     offset;
  logic [pfa_pkg::IDX_W-1:0]      free_idx;
  logic                           in_pool;
  logic                           rd_en;
  logic [pfa_pkg::ROW_W-1:0]      rd_row;
  logic [pfa_pkg::ROW_BITS-1:0]   rd_data;
  pfa_pkg::row_write_t            wr;

  pfa_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign n_pages   = (pool_pages > pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES)) ?
                     pfa_pkg::CNT_W'(pfa_pkg::MAX_PAGES) : pool_pages;
  assign n_minus1  = n_pages - pfa_pkg::CNT_W'(1);
  assign last_row  = n_minus1[pfa_pkg::IDX_W-1:pfa_pkg::BIT_W];
  assign full_rows = n_pages[pfa_pkg::CNT_W-1:pfa_pkg::BIT_W];
  assign rem_bits  = n_pages[pfa_pkg::BIT_W-1:0];

  assign align_target = pfa_pkg::ALIGN_PG_W'(0) -
                        pool_base[pfa_pkg::ALIGN_SHIFT-1:pfa_pkg::PAGE_SHIFT];
  assign base_page_ok = (pool_base[pfa_pkg::PAGE_SHIFT-1:0] == '0);

  assign offset   = faddr - pool_base;
  assign free_idx = offset[pfa_pkg::PAGE_SHIFT+pfa_pkg::IDX_W-1:pfa_pkg::PAGE_SHIFT];
  assign in_pool  = (offset[pfa_pkg::ADDR_W-1:pfa_pkg::PAGE_SHIFT+pfa_pkg::IDX_W] == '0) &&
                    ({1'b0, free_idx} < n_pages);

  always_comb begin
    if ({1'b0, chk_row} < full_rows) begin
      vmask = '1;
    end else if ({1'b0, chk_row} == full_rows) begin
      vmask = (pfa_pkg::ROW_BITS'(1) << rem_bits) - pfa_pkg::ROW_BITS'(1);
    end else begin
      vmask = '0;
    end
  end

  always_comb begin
    for (int b = 0; b < pfa_pkg::ROW_BITS; b++) begin
      bit_idx = {chk_row, pfa_pkg::BIT_W'(b)};
      cand[b] = base_page_ok && (bit_idx[pfa_pkg::ALIGN_PG_W-1:0] == align_target);
    end
  end

  assign avail = ~rd_data & vmask & (big ? cand : '1);
  assign hit   = chk_valid && (avail != '0);

  always_comb begin
    first_bit = '0;
    for (int b = pfa_pkg::ROW_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        first_bit = pfa_pkg::BIT_W'(b);
      end
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_row  = scan_row;
    wr.en   = 1'b0;
    wr.row  = chk_row;
    wr.data = rd_data | (pfa_pkg::ROW_BITS'(1) << first_bit);
    case (state)
      S_SCAN: begin
        rd_en = !scan_done;
        wr.en = hit;
      end
      S_FCHK: begin
        rd_en  = in_pool;
        rd_row = free_idx[pfa_pkg::IDX_W-1:pfa_pkg::BIT_W];
      end
      S_FWR: begin
        wr.en   = 1'b1;
        wr.row  = hit_idx[pfa_pkg::IDX_W-1:pfa_pkg::BIT_W];
        wr.data = rd_data & ~(pfa_pkg::ROW_BITS'(1) << hit_idx[pfa_pkg::BIT_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      pool_pages <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pfa_pkg::REG_POOL_BASE:  pool_base  <= cfg_data;
        pfa_pkg::REG_POOL_PAGES: pool_pages <= cfg_data[pfa_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      chk_valid <= 1'b0;
      scan_done <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            big       <= (cmd == pfa_pkg::CMD_BIG);
            faddr     <= free_address;
            scan_row  <= '0;
            scan_done <= 1'b0;
            chk_valid <= 1'b0;
            chk_row   <= '0;
            fin_hit   <= 1'b0;
            case (cmd)
              pfa_pkg::CMD_PAGE, pfa_pkg::CMD_BIG: begin
                if (n_pages == '0) begin
                  fin_status <= pfa_pkg::ST_OOM;
                  state      <= S_FIN;
                end else begin
                  state <= S_SCAN;
                end
              end
              pfa_pkg::CMD_FREE: begin
                state <= S_FCHK;
              end
              default: begin
                fin_status <= pfa_pkg::ST_OK;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          chk_valid <= !scan_done;
          chk_row   <= scan_row;
          if (!scan_done) begin
            if (scan_row == last_row) begin
              scan_done <= 1'b1;
            end else begin
              scan_row <= scan_row + pfa_pkg::ROW_W'(1);
            end
          end
          if (hit) begin
            hit_idx    <= {chk_row, first_bit};
            fin_hit    <= 1'b1;
            fin_status <= pfa_pkg::ST_OK;
            state      <= S_FIN;
          end else if (chk_valid && chk_row == last_row) begin
            fin_status <= pfa_pkg::ST_OOM;
            state      <= S_FIN;
          end
        end
        S_FCHK: begin
          hit_idx <= free_idx;
          if (in_pool) begin
            fin_status <= pfa_pkg::ST_OK;
            state      <= S_FWR;
          end else begin
            fin_status <= pfa_pkg::ST_OUTSIDE;
            state      <= S_FIN;
          end
        end
        S_FWR: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= fin_status;
            page_address <= fin_hit ?
                            pool_base + (pfa_pkg::ADDR_W'(hit_idx) << pfa_pkg::PAGE_SHIFT) : '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/pfa_bitmap.sv -----
// Used-flag bitmap memory with per-row valid bits cleared at reset.
`timescale 1ns / 1ps

module pfa_bitmap (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [pfa_pkg::ROW_W-1:0]    rd_row,
  output logic [pfa_pkg::ROW_BITS-1:0] rd_data,
  input  pfa_pkg::row_write_t          wr
);

  logic [pfa_pkg::ROW_BITS-1:0] mem [pfa_pkg::ROWS];
  logic [pfa_pkg::ROWS-1:0]     row_valid;
  logic [pfa_pkg::ROW_BITS-1:0] rd_raw;
  logic                         rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.row] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= row_valid[rd_row];
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

// ----- hdl/pfa_checker.sv -----
// Port-level checker for the page frame allocator and its bind.
`timescale 1ns / 1ps

module pfa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pfa_pkg::ADDR_W-1:0]      page_address,
  input logic [1:0]                      status
);

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(page_address) && $stable(status))
    else $error("Result word changed while stalled.");

  // The block works on one word at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted while a word was in progress.");

  // Failures never carry a page address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pfa_pkg::ST_OOM || status == pfa_pkg::ST_OUTSIDE)
      |-> page_address == '0)
    else $error("Failed word carries a page address.");

  // Reset leaves no result pending and the input open.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("Block not idle after reset.");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .page_address (page_address),
  .status       (status)
);

// ----- bench/alloc_checker.sv -----
// Checker for the page frame allocator: tracks the page map, predicts each result and compares.
`timescale 1ns / 1ps

module alloc_checker
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [ADDR_W-1:0]    free_address,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [ADDR_W-1:0]    page_address,
  input  logic [1:0]           status,
  output int                   errors,
  output int                   pending
);

  localparam logic [ADDR_W-1:0] MIB_MASK = 'hFFFFF;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    status_t           st;
  } grant_t;

  logic              used_map [MAX_PAGES];
  logic [ADDR_W-1:0] base_q;
  logic [CNT_W-1:0]  pages_q;
  grant_t            grants_due [$];
  int                shown;

  function automatic int unsigned pool_size();
    return (pages_q > MAX_PAGES) ? MAX_PAGES : int'(pages_q);
  endfunction

  function automatic grant_t claim_page(input logic [1:0] op);
    grant_t            g;
    logic [ADDR_W-1:0] a;
    int unsigned       n;
    g.op   = op;
    g.addr = '0;
    g.st   = ST_OOM;
    n      = pool_size();
    for (int unsigned i = 0; i < n; i++) begin
      if (used_map[i]) continue;
      a = base_q + (ADDR_W'(i) << PAGE_SHIFT);
      if (op == CMD_BIG &&
          ((a & MIB_MASK) != '0 || (a % ADDR_W'(BIG_ALIGN_BYTES)) != '0)) continue;
      used_map[i] = 1'b1;
      g.addr      = a;
      g.st        = ST_OK;
      break;
    end
    return g;
  endfunction

  function automatic grant_t release_page(input logic [ADDR_W-1:0] fa);
    grant_t            g;
    logic [ADDR_W-1:0] off;
    g.op   = CMD_FREE;
    g.addr = '0;
    g.st   = ST_OK;
    off    = fa - base_q;
    if ((off >> PAGE_SHIFT) < pool_size()) begin
      used_map[off[PAGE_SHIFT +: IDX_W]] = 1'b0;
    end else begin
      g.st = ST_OUTSIDE;
    end
    return g;
  endfunction

  function automatic grant_t predict_grant(input logic [1:0] op, input logic [ADDR_W-1:0] fa);
    grant_t g;
    case (op)
      CMD_PAGE, CMD_BIG: g = claim_page(op);
      CMD_FREE: g = release_page(fa);
      default: begin
        g.op   = op;
        g.addr = '0;
        g.st   = ST_OK;
      end
    endcase
    return g;
  endfunction

  // Counters change at the rising edge; the stimulus side reads them at the falling edge.
  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      foreach (used_map[i]) used_map[i] = 1'b0;
      base_q  = '0;
      pages_q = '0;
      grants_due.delete();
      errors = 0;
      shown  = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_POOL_BASE) begin
          base_q = cfg_data;
        end else if (cfg_index == REG_POOL_PAGES) begin
          pages_q = cfg_data[CNT_W-1:0];
        end
      end
      if (in_valid && in_ready) grants_due.push_back(predict_grant(cmd, free_address));
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          errors++;
          if (shown < 10) begin
            $display("unexpected word: address %h status %0d", page_address, status);
            shown++;
          end
        end else begin
          g = grants_due.pop_front();
          if (page_address !== g.addr || status !== g.st) begin
            errors++;
            if (shown < 10) begin
              $display({"mismatch on cmd %0d: expected address %h status %0d, ",
                        "got address %h status %0d"},
                       g.op, g.addr, g.st, page_address, status);
              shown++;
            end
          end
        end
      end
    end
    pending = grants_due.size();
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the page frame allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import pfa_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           cmd = '0;
  logic [ADDR_W-1:0]    free_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    page_address;
  logic [1:0]           status;
  int                   errors;
  int                   pending;

  int cycle_count = 0;
  int stall_left = 0;
  int steady_left = 0;
  bit steady_send = 1'b0;

  page_frame_allocator dut (.*);
  alloc_checker chk (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (steady_left > 0) begin
        steady_left--;
      end else if ($urandom_range(0, 199) == 0) begin
        steady_left = $urandom_range(50, 300);
      end else begin
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_word(input logic [1:0] c, input logic [ADDR_W-1:0] a);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    free_address <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Usually puts a big-page boundary inside the pool so aligned requests can succeed.
  function automatic logic [ADDR_W-1:0] pick_base(input int unsigned nc);
    if ($urandom_range(0, 3) == 0) return rand_addr();
    return (rand_addr() & ~ADDR_W'('h1FFFFF)) -
           (ADDR_W'($urandom_range(0, nc - 1)) << PAGE_SHIFT);
  endfunction

  task automatic random_word(input logic [ADDR_W-1:0] b, input int unsigned nc);
    int                r;
    int unsigned       span;
    logic [1:0]        c;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    a = rand_addr();
    if (r < 40) begin
      c = CMD_PAGE;
    end else if (r < 55) begin
      c = CMD_BIG;
    end else if (r < 93) begin
      c = CMD_FREE;
      r = $urandom_range(0, 9);
      if (r < 8 && nc > 0) begin
        span = (nc > 64) ? 64 : nc;
        a = b + (ADDR_W'($urandom_range(0, span - 1)) << PAGE_SHIFT) +
            ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
      end else if (r < 9) begin
        if ($urandom_range(0, 1) == 1) begin
          a = b + (ADDR_W'(nc) << PAGE_SHIFT) + ADDR_W'($urandom_range(0, 5000));
        end else begin
          a = b - ADDR_W'($urandom_range(1, 5000));
        end
      end
    end else begin
      c = CMD_NONE;
    end
    send_word(c, a);
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] b, input logic [CNT_W-1:0] p,
                           input int count);
    int unsigned nc;
    nc = (p > MAX_PAGES) ? MAX_PAGES : p;
    settle();
    write_reg(REG_POOL_BASE, b);
    write_reg(REG_POOL_PAGES, CFG_W'(p));
    steady_send = ($urandom_range(0, 3) == 0);
    repeat (count) random_word(b, nc);
  endtask

  initial begin
    int unsigned p;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The pool is empty after reset.
    send_word(CMD_PAGE, '0);
    send_word(CMD_BIG, '1);
    send_word(CMD_FREE, '0);
    send_word(CMD_FREE, '1);
    send_word(CMD_NONE, '1);

    // Eight pages with one big-page boundary at the third page.
    settle();
    write_reg(REG_POOL_BASE, 'h1FE000);
    write_reg(REG_POOL_PAGES, 8);
    send_word(CMD_BIG, '0);
    repeat (7) send_word(CMD_PAGE, '0);
    send_word(CMD_PAGE, '0);
    send_word(CMD_BIG, '0);
    send_word(CMD_FREE, 'h1FFFFF);
    send_word(CMD_FREE, 'h1FF000);
    send_word(CMD_FREE, 'h1FDFFF);
    send_word(CMD_FREE, 'h206000);
    send_word(CMD_PAGE, '0);
    send_word(CMD_FREE, 'h200000);
    send_word(CMD_BIG, '0);

    // An oversized page count at the top of the address space, so the pool wraps to zero.
    settle();
    write_reg(REG_POOL_BASE, 'hFFFF_FFFF_6000);
    write_reg(REG_POOL_PAGES, 8191);
    send_word(CMD_PAGE, '0);
    send_word(CMD_PAGE, '0);
    send_word(CMD_BIG, '0);

    run_phase('0, 13'd4096, 60);
    run_phase(pick_base(1), 13'd1, 40);
    repeat (3) begin
      p = $urandom_range(2, 64);
      run_phase(pick_base(p), CNT_W'(p), 70);
    end
    run_phase('1, CNT_W'($urandom_range(16, 200)), 50);
    run_phase(pick_base(64), 13'd4095, 50);

    settle();
    repeat (80) @(negedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
